[src/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg: shared types and codes
// Transaction payloads, result codes and datapath commands of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

  localparam int MEM_CELLS_DEF  = 128;
  localparam int MAX_BLOCKS_DEF = 128;
  localparam logic [7:0] MEM_SIZE_RESET = 8'd128;

  // operation codes
  localparam logic [1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [1:0] FUNC_ERASE  = 2'd1;
  localparam logic [1:0] FUNC_DEFRAG = 2'd2;

  // result codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NULL    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         alloc_length;
    logic signed [31:0] erase_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] given_number;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SCAN_INIT,
    CMD_A_SCAN,
    CMD_FILL,
    CMD_E_LATCH,
    CMD_CLR_WR,
    CMD_D_SCAN,
    CMD_ZERO
  } dp_cmd_t;

  typedef struct packed {
    logic       clear_done;
    logic       a_null;
    logic       e_bad;
    logic       live;
    logic       found;
    logic       scan_end;
    logic       wr_last;
    logic       zero_done;
    logic [1:0] func;
    logic [7:0] given;
  } dp_status_t;

endpackage

`default_nettype wire

[src/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator: first-fit cell allocator with compaction
// Alloc, erase and defragment over a map of cell owners.
// ----------------------------------------------------------------------------
// Input transactions (in_valid/in_ready) carry func, alloc_length and
// erase_number. Alloc answers with one result transaction: allocated with a
// block number, or null. Erase answers only when the number is illegal;
// defragment never answers. Results leave through out_valid/out_ready.
// The cfg channel writes mem_size; it is always ready and is meant to be
// used only while the block is idle.
// One transaction is worked at a time, one cell per cycle on the owner RAM
// port: alloc scans up to mem_size cells, then writes each granted cell;
// erase clears the cells of the block; defragment runs a packing scan, then
// zeros the freed tail. A result waits in an output register; the next
// transaction is taken while it waits, and the block only stalls when a
// second result is ready before the first is taken.
// After reset a clearing pass zeros the owner map and live flags; in_ready
// stays low during it.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator #(
  parameter int MEM_CELLS  = ffba_pkg::MEM_CELLS_DEF,
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ffba_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ffba_pkg::out_item_t      out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [7:0]          cfg_data
);
  import ffba_pkg::*;

  logic [7:0] mem_size;
  dp_cmd_t    cmd;
  dp_status_t status;

  // single config register, writes land immediately
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_size <= MEM_SIZE_RESET;
    end else if (cfg_valid) begin
      mem_size <= cfg_data;
    end
  end

  ffba_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cmd(cmd), .status(status)
  );

  ffba_dp #(.MEM_CELLS(MEM_CELLS), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_item),
    .mem_size(mem_size), .status(status)
  );

  // no transaction is taken in the first cycle of the clearing pass
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ready)
    else $error("input taken during clearing pass");

  // work is one transaction at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  // only a grant carries a block number, and a grant never carries zero
  a_number_rule: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_item.status == ST_ALLOC) == (out_item.given_number != 8'd0)))
    else $error("block number does not match result code");

endmodule

`default_nettype wire

[src/ffba_ram.sv]
// ----------------------------------------------------------------------------
// ffba_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[src/ffba_dp.sv]
// ----------------------------------------------------------------------------
// ffba_dp: allocator datapath
// Cell owner map, block span and live stores, scan cursors and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_dp #(
  parameter int MEM_CELLS  = 128,
  parameter int MAX_BLOCKS = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ffba_pkg::dp_cmd_t    cmd,
  input  wire ffba_pkg::in_item_t   in_item,
  input  wire logic [7:0]           mem_size,
  output ffba_pkg::dp_status_t      status
);
  import ffba_pkg::*;

  localparam int CA      = $clog2(MEM_CELLS + 1);
  localparam int BA      = $clog2(MAX_BLOCKS + 1);
  localparam int CW      = $clog2(MEM_CELLS + 2);
  localparam int SW      = (CW > 8) ? CW : 8;
  localparam int CLR_MAX = (MEM_CELLS > MAX_BLOCKS) ? MEM_CELLS : MAX_BLOCKS;
  localparam int KW      = $clog2(CLR_MAX + 1);
  localparam logic [CW-1:0] CELL_LAST = CW'(MEM_CELLS);
  localparam logic [BA-1:0] BLK_LAST  = BA'(MAX_BLOCKS);

  // item
  logic [1:0]  func;
  logic [7:0]  len;
  logic [31:0] xnum;
  // cursors
  logic [CW-1:0] cur, rd_cell, run, wall, wp, wend;
  logic          rd_pend;
  logic [BA-1:0] prev, blocks_issued, blk;
  logic [CA-1:0] cur_first;
  logic [KW-1:0] clr;

  // RAM ports
  logic          own_we;
  logic [CA-1:0] own_waddr, own_raddr;
  logic [BA-1:0] own_wdata, owner_rdata;
  logic          span_we;
  logic [BA-1:0] span_waddr;
  logic [2*CA-1:0] span_wdata, span_rdata;
  logic          live_we, live_wdata, live_rdata;
  logic [BA-1:0] live_waddr;

  logic [SW-1:0] msz, sz_w;
  logic [CW-1:0] sz, limit, run_new, start_c, wpos;
  logic          issue, found, scan_end, dwrite, new_blk;
  logic [BA-1:0] xaddr, blk_next;
  logic [CA-1:0] dfirst;

  assign msz      = SW'(mem_size);
  assign sz_w     = (msz > SW'(MEM_CELLS)) ? SW'(MEM_CELLS) : msz;
  assign sz       = sz_w[CW-1:0];
  assign limit    = (cmd == CMD_D_SCAN) ? CELL_LAST : sz;
  assign issue    = (cur <= limit);
  assign run_new  = (owner_rdata == '0) ? run + CW'(1) : '0;
  assign found    = (cmd == CMD_A_SCAN) && rd_pend && (SW'(run_new) == SW'(len));
  assign scan_end = !rd_pend && !issue;
  assign start_c  = rd_cell - CW'(len) + CW'(1);
  assign xaddr    = xnum[BA-1:0];
  assign blk_next = blocks_issued + BA'(1);
  assign dwrite   = (cmd == CMD_D_SCAN) && rd_pend && (owner_rdata != '0);
  assign new_blk  = (owner_rdata != prev);
  assign wpos     = wall + CW'(1);
  assign dfirst   = new_blk ? wpos[CA-1:0] : cur_first;
  assign own_raddr = issue ? cur[CA-1:0] : '0;

  always_comb begin
    own_we     = 1'b0;
    own_waddr  = wp[CA-1:0];
    own_wdata  = '0;
    span_we    = 1'b0;
    span_waddr = xaddr;
    span_wdata = '0;
    live_we    = 1'b0;
    live_waddr = xaddr;
    live_wdata = 1'b0;
    unique case (cmd)
      CMD_CLEAR: begin
        own_we     = (clr <= KW'(MEM_CELLS));
        own_waddr  = clr[CA-1:0];
        live_we    = (clr <= KW'(MAX_BLOCKS));
        live_waddr = clr[BA-1:0];
      end
      CMD_A_SCAN: begin
        span_we    = found;
        span_waddr = blk_next;
        span_wdata = {start_c[CA-1:0], rd_cell[CA-1:0]};
        live_we    = found;
        live_waddr = blk_next;
        live_wdata = 1'b1;
      end
      CMD_FILL: begin
        own_we    = 1'b1;
        own_wdata = blk;
      end
      CMD_E_LATCH: begin
        live_we = 1'b1;
      end
      CMD_CLR_WR: begin
        own_we = 1'b1;
      end
      CMD_D_SCAN: begin
        own_we     = dwrite;
        own_waddr  = wpos[CA-1:0];
        own_wdata  = owner_rdata;
        span_we    = dwrite;
        span_waddr = owner_rdata;
        span_wdata = {dfirst, wpos[CA-1:0]};
      end
      CMD_ZERO: begin
        own_we = (wp <= CELL_LAST);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr           <= '0;
      blocks_issued <= '0;
      rd_pend       <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_CLEAR: begin
          if (clr != KW'(CLR_MAX)) begin
            clr <= clr + KW'(1);
          end
        end
        CMD_LOAD: begin
          func <= in_item.func;
          len  <= in_item.alloc_length;
          xnum <= in_item.erase_number;
        end
        CMD_SCAN_INIT: begin
          cur     <= CW'(1);
          rd_pend <= 1'b0;
          run     <= '0;
          wall    <= '0;
          prev    <= '0;
        end
        CMD_A_SCAN, CMD_D_SCAN: begin
          rd_pend <= issue;
          rd_cell <= cur;
          if (issue) begin
            cur <= cur + CW'(1);
          end
          if (rd_pend) begin
            run  <= run_new;
            prev <= owner_rdata;
          end
          if (found) begin
            blocks_issued <= blk_next;
            blk           <= blk_next;
            wp            <= start_c;
            wend          <= rd_cell;
          end
          if (dwrite) begin
            wall <= wpos;
            if (new_blk) begin
              cur_first <= wpos[CA-1:0];
            end
          end
          if ((cmd == CMD_D_SCAN) && scan_end) begin
            wp <= wpos;
          end
        end
        CMD_FILL, CMD_CLR_WR, CMD_ZERO: begin
          wp <= wp + CW'(1);
        end
        CMD_E_LATCH: begin
          wp   <= CW'(span_rdata[2*CA-1:CA]);
          wend <= CW'(span_rdata[CA-1:0]);
        end
        default: ;
      endcase
    end
  end

  ffba_ram #(.WIDTH(BA), .DEPTH(MEM_CELLS + 1)) u_owner (
    .clk(clk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
    .raddr(own_raddr), .rdata(owner_rdata)
  );

  ffba_ram #(.WIDTH(2 * CA), .DEPTH(MAX_BLOCKS + 1)) u_span (
    .clk(clk), .we(span_we), .waddr(span_waddr), .wdata(span_wdata),
    .raddr(xaddr), .rdata(span_rdata)
  );

  ffba_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS + 1)) u_live (
    .clk(clk), .we(live_we), .waddr(live_waddr), .wdata(live_wdata),
    .raddr(xaddr), .rdata(live_rdata)
  );

  always_comb begin
    status.clear_done = (clr == KW'(CLR_MAX));
    status.a_null     = (blocks_issued >= BLK_LAST) || (len == 8'd0) ||
                        (SW'(len) > sz_w);
    status.e_bad      = xnum[31] || (xnum == 32'd0) || (xnum > 32'(blocks_issued));
    status.live       = live_rdata;
    status.found      = found;
    status.scan_end   = scan_end;
    status.wr_last    = (wp == wend);
    status.zero_done  = (wp > CELL_LAST);
    status.func       = func;
    status.given      = 8'(blk);
  end

endmodule

`default_nettype wire

[src/ffba_ctrl.sv]
// ----------------------------------------------------------------------------
// ffba_ctrl: allocator controller
// Sequences each operation and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ffba_pkg::out_item_t        out_item,
  output ffba_pkg::dp_cmd_t          cmd,
  input  wire ffba_pkg::dp_status_t  status
);
  import ffba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_A_SCAN, S_A_FILL,
    S_E_CHK, S_E_CLR, S_D_SCAN, S_D_ZERO, S_RESP
  } state_t;

  state_t     state;
  logic [1:0] res_code;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = CMD_NONE;
    unique case (state)
      S_CLEAR:  cmd = CMD_CLEAR;
      S_IDLE:   cmd = in_valid ? CMD_LOAD : CMD_NONE;
      S_DECODE: begin
        if (((status.func == FUNC_ALLOC) && !status.a_null) ||
            (status.func == FUNC_DEFRAG)) begin
          cmd = CMD_SCAN_INIT;
        end
      end
      S_A_SCAN: cmd = CMD_A_SCAN;
      S_A_FILL: cmd = CMD_FILL;
      S_E_CHK:  cmd = status.live ? CMD_E_LATCH : CMD_NONE;
      S_E_CLR:  cmd = CMD_CLR_WR;
      S_D_SCAN: cmd = CMD_D_SCAN;
      S_D_ZERO: cmd = status.zero_done ? CMD_NONE : CMD_ZERO;
      S_RESP:   cmd = CMD_NONE;
      default:  cmd = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      // in S_RESP a taken result is replaced by the new one below
      if (out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: if (status.clear_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_DECODE;
        S_DECODE: begin
          priority if (status.func == FUNC_ALLOC) begin
            if (status.a_null) begin
              res_code <= ST_NULL;
              state    <= S_RESP;
            end else begin
              state <= S_A_SCAN;
            end
          end else if (status.func == FUNC_ERASE) begin
            if (status.e_bad) begin
              res_code <= ST_ILLEGAL;
              state    <= S_RESP;
            end else begin
              state <= S_E_CHK;
            end
          end else if (status.func == FUNC_DEFRAG) begin
            state <= S_D_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_A_SCAN: begin
          priority if (status.found) begin
            state <= S_A_FILL;
          end else if (status.scan_end) begin
            res_code <= ST_NULL;
            state    <= S_RESP;
          end
        end
        S_A_FILL: begin
          if (status.wr_last) begin
            res_code <= ST_ALLOC;
            state    <= S_RESP;
          end
        end
        S_E_CHK: begin
          if (status.live) begin
            state <= S_E_CLR;
          end else begin
            res_code <= ST_ILLEGAL;
            state    <= S_RESP;
          end
        end
        S_E_CLR:  if (status.wr_last) state <= S_IDLE;
        S_D_SCAN: if (status.scan_end) state <= S_D_ZERO;
        S_D_ZERO: if (status.zero_done) state <= S_IDLE;
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_item.status       <= res_code;
            out_item.given_number <= (res_code == ST_ALLOC) ? status.given : 8'd0;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
